### rtl/abump_pkg.sv
// ----------------------------------------------------------------------------
// Arena bump allocator package
// Shared constants, command and status codes, and the stack control word
// passed from the allocation logic to the size stack.
// ----------------------------------------------------------------------------
`default_nettype none

package abump_pkg;

   // Width of addresses, sizes and offsets
   localparam int DATA_W = 32;

   // Depth of the stack of padded block sizes
   localparam int STACK_DEPTH = 64;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam logic [CNT_W-1:0] DEPTH_COUNT = CNT_W'(STACK_DEPTH);

   // Configuration register widths and reset values
   localparam int ALIGN_W   = 3;
   localparam int CSR_IDX_W = 2;
   localparam logic [DATA_W-1:0]  CAPACITY_RESET = DATA_W'(4096);
   localparam logic [DATA_W-1:0]  BASE_RESET     = '0;
   localparam logic [ALIGN_W-1:0] ALIGN_RESET    = ALIGN_W'(3);

   // Request commands
   typedef enum logic [1:0] {
      CMD_ALLOC     = 2'd0,
      CMD_FREE_ADDR = 2'd1,
      CMD_FREE_SIZE = 2'd2,
      CMD_REALLOC   = 2'd3
   } cmd_type;

   // Response status codes
   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_ZERO    = 3'd1,
      ST_NOSPACE = 3'd2,
      ST_RING    = 3'd3,
      ST_NOTTOP  = 3'd4,
      ST_FULL    = 3'd5,
      ST_UNDER   = 3'd6
   } status_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE     = 2'd0,
      CSR_CAPACITY = 2'd1,
      CSR_BASE     = 2'd2,
      CSR_ALIGN    = 2'd3
   } csr_index_type;

   // Stack operation for one word; a pop and a push together replace the top
   typedef struct packed {
      logic              push;
      logic              pop;
      logic [DATA_W-1:0] data;
   } stack_ctl_type;

endpackage

`default_nettype wire

### rtl/arena_bump_allocator.sv
// An accepted request word passes through the input register, then the result
// register, before its result appears on the response side.
// Throughput: one request per cycle unless the response stalls; the offset
// and stack top update in the same cycle a request enters the result register.
// Reset clears the used offset, the stack count and both valid flags, and
// loads the configuration defaults; the size memory is not cleared.
// ----------------------------------------------------------------------------
// Arena bump allocator
// Bump allocator over one arena with a stack of padded block sizes, free by
// address of the top block, free by size and reallocation.
// ----------------------------------------------------------------------------
`default_nettype none

module arena_bump_allocator import abump_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [2*DATA_W-1:0]   req_tdata,   // size [31:0], address [63:32]
   input  wire logic [1:0]            req_tuser,   // cmd [1:0]
   // Response channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [2*DATA_W-1:0]        rsp_tdata,   // block_address [31:0], used_bytes [63:32]
   output logic [2:0]                 rsp_tuser,   // status [2:0]
   // Configuration write channel
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [DATA_W-1:0]     csr_data
);

   // Configuration registers
   logic               mode_ff;
   logic [DATA_W-1:0]  capacity_ff;
   logic [DATA_W-1:0]  base_ff;
   logic [ALIGN_W-1:0] align_ff;

   // Input register
   logic               in_valid_ff;
   logic               in_valid_in;
   cmd_type            in_cmd_ff;
   logic [DATA_W-1:0]  in_size_ff;
   logic [DATA_W-1:0]  in_addr_ff;

   // Result register
   logic               out_valid_ff;
   logic               out_valid_in;
   logic [DATA_W-1:0]  out_block_ff;
   logic [DATA_W-1:0]  out_used_ff;
   status_type         out_status_ff;

   // Allocator state
   logic [DATA_W-1:0]  used_ff;
   logic [DATA_W-1:0]  used_in;

   logic               req_accept;
   logic               advance;
   logic               fire;
   logic [CNT_W-1:0]   stack_count;
   logic [DATA_W-1:0]  stack_top;
   stack_ctl_type      core_ctl;
   stack_ctl_type      stack_ctl;
   logic [DATA_W-1:0]  used_next;
   logic [DATA_W-1:0]  block_address;
   status_type         status;

   // Handshake: a word moves on whenever the result register is free or drains
   assign advance      = !out_valid_ff || rsp_tready;
   assign fire         = in_valid_ff && advance;
   assign req_tready   = !in_valid_ff || advance;
   assign req_accept   = req_tvalid && req_tready;
   assign in_valid_in  = req_accept || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && !rsp_tready);
   assign csr_ready    = 1'b1;

   // Allocation logic
   abump_core u_core (
      .cmd           (in_cmd_ff),
      .size          (in_size_ff),
      .address       (in_addr_ff),
      .mode          (mode_ff),
      .capacity      (capacity_ff),
      .arena_base    (base_ff),
      .align_log2    (align_ff),
      .used_offset   (used_ff),
      .stack_count   (stack_count),
      .stack_top     (stack_top),
      .used_next     (used_next),
      .stack_ctl     (core_ctl),
      .block_address (block_address),
      .status        (status)
   );

   // Stack and offset change only when the word moves on
   assign stack_ctl = fire ? core_ctl : '0;
   assign used_in   = fire ? used_next : used_ff;

   abump_stack u_stack (
      .clock       (clock),
      .reset       (reset),
      .ctl         (stack_ctl),
      .stack_count (stack_count),
      .stack_top   (stack_top)
   );

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         used_ff      <= '0;
         mode_ff      <= 1'b0;
         capacity_ff  <= CAPACITY_RESET;
         base_ff      <= BASE_RESET;
         align_ff     <= ALIGN_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         used_ff      <= used_in;
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_MODE:     mode_ff     <= csr_data[0];
               CSR_CAPACITY: capacity_ff <= csr_data;
               CSR_BASE:     base_ff     <= csr_data;
               CSR_ALIGN:    align_ff    <= csr_data[ALIGN_W-1:0];
               default:      mode_ff     <= mode_ff;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_cmd_ff  <= cmd_type'(req_tuser);
         in_size_ff <= req_tdata[DATA_W-1:0];
         in_addr_ff <= req_tdata[2*DATA_W-1:DATA_W];
      end
      if (fire) begin
         out_block_ff  <= block_address;
         out_used_ff   <= used_next;
         out_status_ff <= status;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_used_ff, out_block_ff};
   assign rsp_tuser  = out_status_ff;

endmodule

`default_nettype wire

### rtl/abump_stack.sv
// ----------------------------------------------------------------------------
// Size stack
// Holds the padded size of every live block. The top entry is kept in a
// register, and the entry below it is read from the memory every cycle so
// that a pop can refill the top without a stall.
// ----------------------------------------------------------------------------
`default_nettype none

module abump_stack import abump_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire stack_ctl_type     ctl,
   output logic [CNT_W-1:0]       stack_count,
   output logic [DATA_W-1:0]      stack_top
);

   logic [DATA_W-1:0] mem [STACK_DEPTH];
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [DATA_W-1:0] top_ff;
   logic [DATA_W-1:0] top_in;
   logic [DATA_W-1:0] below_ff;
   logic [CNT_W-1:0]  wr_pos;
   logic [CNT_W-1:0]  rd_pos;
   logic [IDX_W-1:0]  wr_idx;
   logic [IDX_W-1:0]  rd_idx;

   // Count after this word; a push goes to the slot above what remains
   assign count_in = count_ff - CNT_W'(ctl.pop) + CNT_W'(ctl.push);
   assign wr_pos   = count_ff - CNT_W'(ctl.pop);
   assign wr_idx   = wr_pos[IDX_W-1:0];

   // Keep the entry just below the next top ready for a following pop
   assign rd_pos = count_in - CNT_W'(2);
   assign rd_idx = rd_pos[IDX_W-1:0];

   // New top: the pushed size, or the prefetched entry after a pop
   always_comb begin
      if (ctl.push) begin
         top_in = ctl.data;
      end else if (ctl.pop) begin
         top_in = below_ff;
      end else begin
         top_in = top_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Top register, memory write and registered read
   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (ctl.push) begin
         mem[wr_idx] <= ctl.data;
      end
      below_ff <= mem[rd_idx];
   end

   assign stack_count = count_ff;
   assign stack_top   = top_ff;

   // The count never passes the depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_COUNT)
      else $error("size stack count beyond depth");

   // A pop is only issued on a non-empty stack
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      ctl.pop |-> count_ff != '0)
      else $error("pop on empty size stack");

   // A push only goes where there is room
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      ctl.push |-> wr_pos < DEPTH_COUNT)
      else $error("push on full size stack");

   // After a plain pop the top is the prefetched entry below
   a_refill: assert property (@(posedge clock) disable iff (reset)
      (ctl.pop && !ctl.push && count_ff > CNT_W'(1)) |=> top_ff == $past(below_ff))
      else $error("size stack top not refilled after pop");

endmodule

`default_nettype wire

### rtl/abump_core.sv
// ----------------------------------------------------------------------------
// Allocation logic
// Works out the result and the next offset and stack operation for one
// request from the current offset, the stack top and the configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module abump_core import abump_pkg::*; (
   input  wire cmd_type           cmd,
   input  wire logic [DATA_W-1:0] size,
   input  wire logic [DATA_W-1:0] address,
   input  wire logic              mode,
   input  wire logic [DATA_W-1:0] capacity,
   input  wire logic [DATA_W-1:0] arena_base,
   input  wire logic [ALIGN_W-1:0] align_log2,
   input  wire logic [DATA_W-1:0] used_offset,
   input  wire logic [CNT_W-1:0]  stack_count,
   input  wire logic [DATA_W-1:0] stack_top,
   output logic [DATA_W-1:0]      used_next,
   output stack_ctl_type          stack_ctl,
   output logic [DATA_W-1:0]      block_address,
   output status_type             status
);

   logic [DATA_W-1:0] top_start;
   logic              top_match;
   logic              pop_under;
   logic [DATA_W-1:0] used_pop;
   logic              realloc_pop;
   logic [DATA_W-1:0] alloc_base;
   logic [CNT_W-1:0]  alloc_count;
   logic [DATA_W:0]   fit_sum;
   logic              overflow;
   logic              wrap;
   logic [DATA_W-1:0] prev;
   logic [DATA_W:0]   next_raw;
   logic [7:0]        amask;
   logic [DATA_W+1:0] next_round;
   logic [DATA_W-1:0] next_sat;
   status_type        alloc_status;

   // Top block start and whether the request names it
   assign top_start = used_offset - stack_top;
   assign top_match = (stack_count != '0) && ((arena_base + top_start) == address);
   assign pop_under = stack_top > used_offset;
   assign used_pop  = pop_under ? '0 : top_start;

   // A reallocation of the top block pops it before allocating
   assign realloc_pop = (cmd == CMD_REALLOC) && (size != '0) && top_match;
   assign alloc_base  = realloc_pop ? used_pop : used_offset;
   assign alloc_count = realloc_pop ? stack_count - CNT_W'(1) : stack_count;

   // Fit check; a circular arena restarts at zero when the block does not fit
   assign fit_sum  = {1'b0, alloc_base} + {1'b0, size};
   assign overflow = fit_sum > {1'b0, capacity};
   assign wrap     = mode && overflow;
   assign prev     = wrap ? '0 : alloc_base;
   assign next_raw = wrap ? {1'b0, size} : fit_sum;

   // Round the new offset up to the alignment and saturate at all ones
   assign amask      = ~(8'hFF << align_log2);
   assign next_round = ({1'b0, next_raw} + (DATA_W+2)'(amask)) & ~((DATA_W+2)'(amask));
   assign next_sat   = (next_round[DATA_W+1:DATA_W] != 2'b00) ? '1
                                                             : next_round[DATA_W-1:0];

   // Allocation status in order of precedence
   always_comb begin
      if (size == '0) begin
         alloc_status = ST_ZERO;
      end else if (alloc_count >= DEPTH_COUNT) begin
         alloc_status = ST_FULL;
      end else if (!mode && overflow) begin
         alloc_status = ST_NOSPACE;
      end else if (mode && (size > capacity)) begin
         alloc_status = ST_RING;
      end else begin
         alloc_status = ST_OK;
      end
   end

   // Result and state update per command
   always_comb begin
      used_next      = used_offset;
      stack_ctl      = '0;
      block_address  = '0;
      status         = ST_OK;
      case (cmd)
         CMD_ALLOC: begin
            status = alloc_status;
            if (alloc_status == ST_OK) begin
               used_next      = next_sat;
               stack_ctl.push = 1'b1;
               stack_ctl.data = next_sat - prev;
               block_address  = arena_base + prev;
            end
         end
         CMD_FREE_ADDR: begin
            if (top_match) begin
               stack_ctl.pop = 1'b1;
               used_next     = used_pop;
               status        = pop_under ? ST_UNDER : ST_OK;
            end else begin
               status = ST_NOTTOP;
            end
         end
         CMD_FREE_SIZE: begin
            if (size > used_offset) begin
               used_next = '0;
               status    = ST_UNDER;
            end else begin
               used_next = used_offset - size;
            end
         end
         CMD_REALLOC: begin
            if (realloc_pop) begin
               stack_ctl.pop = 1'b1;
               used_next     = used_pop;
            end
            status = alloc_status;
            if (alloc_status == ST_OK) begin
               used_next      = next_sat;
               stack_ctl.push = 1'b1;
               stack_ctl.data = next_sat - prev;
               block_address  = arena_base + prev;
               if (realloc_pop && pop_under) begin
                  status = ST_UNDER;
               end
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

endmodule

`default_nettype wire
